/* rtl/slw_pkg.sv */
// Shared command, status and controller types for the log window.
package slw_pkg;
	localparam logic [3:0] CMD_APPEND    = 4'd0;
	localparam logic [3:0] CMD_APPEND_AT = 4'd1;
	localparam logic [3:0] CMD_TERM_AT   = 4'd2;
	localparam logic [3:0] CMD_TRUNC_SUF = 4'd3;
	localparam logic [3:0] CMD_TRUNC_PRE = 4'd4;
	localparam logic [3:0] CMD_SET_SNAP  = 4'd5;
	localparam logic [3:0] CMD_RANGE     = 4'd6;
	localparam logic [3:0] CMD_CAN_SERVE = 4'd7;
	localparam logic [3:0] CMD_CLEAR     = 4'd8;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_REJ  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam int RESULT_LIMIT = 64;

	// controller -> datapath
	typedef struct packed {
		logic latch;     // capture command operands
		logic rd_head;   // read oldest slot
		logic rd_tail;   // read newest slot
		logic rd_off;    // read slot at walk offset
		logic exec;      // run single-result command with head data
		logic pop_tail;  // drop newest entry
		logic pop_head;  // drop oldest entry
		logic fix_last;  // recompute last sequence after suffix truncation
		logic rng_init;  // set up range walk
		logic rng_emit;  // emit one range entry
		logic emit_done; // emit plain done result
		logic emit_term; // emit term read from the offset slot
	} slw_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [3:0] command;
		logic       empty;
		logic       tail_ge;   // newest seq >= seq_arg
		logic       head_le;   // oldest seq <= seq_arg
		logic       rng_ok;    // range has entries
		logic       rng_more;  // more range entries after this one
		logic       term_hit;  // term lookup needs the slot at the offset
	} slw_stat_t;
endpackage

/* rtl/slw_datapath.sv */
// Datapath of the log window: ring memory, window registers and result register.
module slw_datapath
	import slw_pkg::*;
#(
	parameter int LOG_DEPTH    = 64,
	parameter int SEQ_BITS     = 32,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [3:0]  command,
	input  logic [31:0] seq_arg,
	input  logic [31:0] term_arg,
	input  logic [31:0] payload_in,
	input  logic [6:0]  max_count,
	input  slw_cmd_t    cmd,
	output slw_stat_t   stat,
	output logic        strobe,
	output logic [1:0]  status,
	output logic [31:0] seq_out,
	output logic [31:0] term_out,
	output logic [31:0] payload_out,
	output logic        last
);
	localparam int IW = $clog2(LOG_DEPTH);
	localparam int CW = $clog2(LOG_DEPTH + 1);
	localparam int NW = (CW > 7) ? CW : 7;
	localparam logic [SEQ_BITS-1:0] SEQ_MAX = {SEQ_BITS{1'b1}};
	localparam int PW = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
	localparam int SW = (SEQ_BITS < 32) ? SEQ_BITS : 32;

	logic [SEQ_BITS-1:0]     mem_seq [LOG_DEPTH];
	logic [31:0]             mem_term [LOG_DEPTH];
	logic [PAYLOAD_BITS-1:0] mem_pay [LOG_DEPTH];

	logic [IW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [SEQ_BITS-1:0] last_seq_q, dropped_q, snap_seq_q;
	logic [31:0] snap_term_q;

	logic [3:0] cmd_q;
	logic [SEQ_BITS-1:0] arg_seq_q;
	logic [31:0] arg_term_q;
	logic [PAYLOAD_BITS-1:0] arg_pay_q;
	logic [6:0] maxc_q;

	logic [SEQ_BITS-1:0] rd_seq_q;
	logic [31:0] rd_term_q;
	logic [PAYLOAD_BITS-1:0] rd_pay_q;

	logic [CW-1:0] off_q;     // walk offset from head
	logic [6:0]    left_q;    // range results still to emit

	logic        strobe_q, last_q;
	logic [1:0]  status_q;
	logic [31:0] seq_out_q, term_out_q, pay_out_q;

	// head + offset is below twice the depth: one conditional subtract wraps it
	function automatic logic [IW-1:0] ring_wrap(input logic [CW:0] pos);
		if (pos >= (CW+1)'(LOG_DEPTH)) return IW'(pos - (CW+1)'(LOG_DEPTH));
		return IW'(pos);
	endfunction

	// address mux
	logic [IW-1:0] rd_addr, wr_addr;
	logic [CW:0]   sum_tail, sum_off, sum_wr;
	always_comb begin
		sum_tail = {1'b0, CW'(head_q)} + {1'b0, count_q} - (CW+1)'(1);
		sum_off  = {1'b0, CW'(head_q)} + {1'b0, off_q};
		sum_wr   = {1'b0, CW'(head_q)} + {1'b0, count_q};
		if (cmd.rd_tail)
			rd_addr = ring_wrap(sum_tail);
		else if (cmd.rd_off)
			rd_addr = ring_wrap(sum_off);
		else
			rd_addr = head_q;
		wr_addr = ring_wrap(sum_wr);
	end

	// append decision
	logic at_max, full, do_store;
	logic [1:0] app_st;
	always_comb begin
		at_max = (last_seq_q == SEQ_MAX);
		full   = (count_q >= CW'(LOG_DEPTH));
		if (at_max || (cmd_q == CMD_APPEND_AT && arg_seq_q != last_seq_q + 1'b1))
			app_st = ST_REJ;
		else if (full)
			app_st = ST_FULL;
		else
			app_st = ST_OK;
		do_store = cmd.exec && (cmd_q == CMD_APPEND || cmd_q == CMD_APPEND_AT)
			&& app_st == ST_OK;
	end

	// lookup of arg_seq against head slot just read
	logic [SEQ_BITS-1:0] diff;
	logic found;
	always_comb begin
		diff  = arg_seq_q - rd_seq_q;
		found = (count_q != '0) && (arg_seq_q <= last_seq_q) && (arg_seq_q >= rd_seq_q)
			&& (diff < SEQ_BITS'(count_q));
	end

	// term lookup that has to fetch the slot at the offset
	logic term_hit;
	assign term_hit = (cmd_q == CMD_TERM_AT) && (arg_seq_q != '0)
		&& (arg_seq_q != snap_seq_q) && found;

	always_ff @(posedge clk) begin
		if (do_store) begin
			mem_seq[wr_addr]  <= last_seq_q + 1'b1;
			mem_term[wr_addr] <= arg_term_q;
			mem_pay[wr_addr]  <= arg_pay_q;
		end
		rd_seq_q  <= mem_seq[rd_addr];
		rd_term_q <= mem_term[rd_addr];
		rd_pay_q  <= mem_pay[rd_addr];
		if (cmd.latch) begin
			cmd_q      <= command;
			arg_seq_q  <= SEQ_BITS'(seq_arg);
			arg_term_q <= term_arg;
			arg_pay_q  <= PAYLOAD_BITS'(payload_in);
			maxc_q     <= max_count;
		end
	end

	logic [CW-1:0] avail;
	logic [6:0]    nres;
	always_comb begin
		avail = count_q - CW'(diff);
		nres  = maxc_q;
		if (nres > 7'(RESULT_LIMIT)) nres = 7'(RESULT_LIMIT);
		if (NW'(avail) < NW'(nres)) nres = 7'(avail);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0; count_q <= '0; last_seq_q <= '0; dropped_q <= '0;
			snap_seq_q <= '0; snap_term_q <= '0; strobe_q <= 1'b0;
			last_q <= 1'b0; status_q <= '0; seq_out_q <= '0; term_out_q <= '0;
			pay_out_q <= '0; off_q <= '0; left_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (cmd.pop_tail) count_q <= count_q - 1'b1;
			if (cmd.pop_head) begin
				dropped_q <= rd_seq_q;
				head_q    <= (head_q == IW'(LOG_DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_q   <= count_q - 1'b1;
			end
			if (cmd.fix_last) begin
				if (count_q != '0) last_seq_q <= rd_seq_q;
				else last_seq_q <= (snap_seq_q > dropped_q) ? snap_seq_q : dropped_q;
			end
			if (cmd.emit_done) begin
				strobe_q <= 1'b1; last_q <= 1'b1; status_q <= ST_OK;
				seq_out_q <= '0; term_out_q <= '0; pay_out_q <= '0;
			end
			if (cmd.emit_term) begin
				strobe_q <= 1'b1; last_q <= 1'b1; status_q <= ST_OK;
				seq_out_q <= '0; term_out_q <= rd_term_q; pay_out_q <= '0;
			end
			if (cmd.rng_init) begin
				off_q  <= CW'(diff);
				left_q <= nres;
				if (!(found && maxc_q != '0)) begin
					strobe_q <= 1'b1; last_q <= 1'b1; status_q <= ST_REJ;
					seq_out_q <= '0; term_out_q <= '0; pay_out_q <= '0;
				end
			end
			if (cmd.rng_emit) begin
				strobe_q   <= 1'b1;
				status_q   <= ST_OK;
				last_q     <= (left_q == 7'd1);
				seq_out_q  <= 32'(rd_seq_q[SW-1:0]);
				term_out_q <= rd_term_q;
				pay_out_q  <= 32'(rd_pay_q[PW-1:0]);
				left_q     <= left_q - 1'b1;
				off_q      <= off_q + 1'b1;
			end
			if (cmd.exec) begin
				// a slot lookup answers later, after the offset read
				strobe_q <= !term_hit; last_q <= 1'b1;
				seq_out_q <= '0; term_out_q <= '0; pay_out_q <= '0;
				status_q <= ST_OK;
				case (cmd_q)
					CMD_APPEND, CMD_APPEND_AT: begin
						status_q <= app_st;
						if (app_st == ST_OK) begin
							seq_out_q  <= 32'((last_seq_q + 1'b1) & SEQ_BITS'({SW{1'b1}}));
							last_seq_q <= last_seq_q + 1'b1;
							count_q    <= count_q + 1'b1;
						end
					end
					CMD_TERM_AT: begin
						off_q <= CW'(diff);
						if (arg_seq_q != '0 && arg_seq_q == snap_seq_q)
							term_out_q <= snap_term_q;
						else if (arg_seq_q != '0 && !found)
							status_q <= ST_REJ;
					end
					CMD_SET_SNAP: begin
						snap_seq_q  <= arg_seq_q;
						snap_term_q <= arg_term_q;
						if (last_seq_q < arg_seq_q) last_seq_q <= arg_seq_q;
						if (dropped_q < arg_seq_q) dropped_q <= arg_seq_q;
					end
					CMD_CAN_SERVE: begin
						if (!at_max && arg_seq_q == last_seq_q + 1'b1) status_q <= ST_OK;
						else if (count_q != '0)
							status_q <= (arg_seq_q >= rd_seq_q && arg_seq_q <= last_seq_q)
								? ST_OK : ST_REJ;
						else
							status_q <= (arg_seq_q > dropped_q && arg_seq_q <= last_seq_q)
								? ST_OK : ST_REJ;
					end
					CMD_CLEAR: begin
						head_q <= '0; count_q <= '0; last_seq_q <= '0; dropped_q <= '0;
					end
					default: status_q <= ST_REJ;
				endcase
			end
		end
	end

	assign stat.command  = cmd_q;
	assign stat.empty    = (count_q == '0);
	assign stat.tail_ge  = (rd_seq_q >= arg_seq_q);
	assign stat.head_le  = (rd_seq_q <= arg_seq_q);
	assign stat.rng_ok   = found && maxc_q != '0;
	assign stat.rng_more = (left_q > 7'd1);
	assign stat.term_hit = term_hit;

	assign strobe      = strobe_q;
	assign status      = status_q;
	assign seq_out     = seq_out_q;
	assign term_out    = term_out_q;
	assign payload_out = pay_out_q;
	assign last        = last_q;
endmodule

/* rtl/slw_ctrl.sv */
// Controller state machine of the log window.
module slw_ctrl
	import slw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  slw_stat_t stat,
	output slw_cmd_t  cmd,
	output logic      busy
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_HEAD  = 4'd1;
	localparam logic [3:0] S_EXEC  = 4'd2;
	localparam logic [3:0] S_TOFF  = 4'd3;
	localparam logic [3:0] S_TWAIT = 4'd4;
	localparam logic [3:0] S_STAIL = 4'd5;
	localparam logic [3:0] S_SCHK  = 4'd6;
	localparam logic [3:0] S_SFIX  = 4'd7;
	localparam logic [3:0] S_PHEAD = 4'd8;
	localparam logic [3:0] S_PCHK  = 4'd9;
	localparam logic [3:0] S_RINIT = 4'd10;
	localparam logic [3:0] S_RRD   = 4'd11;
	localparam logic [3:0] S_REMIT = 4'd12;
	localparam logic [3:0] S_SLAST = 4'd13;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) begin
				cmd.latch = 1'b1;
				state_d = S_HEAD;
			end
			S_HEAD: begin
				cmd.rd_head = 1'b1;
				case (stat.command)
					CMD_TRUNC_SUF: state_d = S_STAIL;
					CMD_TRUNC_PRE: state_d = S_PHEAD;
					CMD_RANGE:     state_d = S_RINIT;
					default:       state_d = S_EXEC;
				endcase
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = stat.term_hit ? S_TOFF : S_IDLE;
			end
			S_TOFF: begin
				cmd.rd_off = 1'b1;
				state_d = S_TWAIT;
			end
			S_TWAIT: begin
				cmd.emit_term = 1'b1;
				state_d = S_IDLE;
			end
			S_STAIL: begin
				cmd.rd_tail = 1'b1;
				state_d = S_SCHK;
			end
			S_SCHK: begin
				if (!stat.empty && stat.tail_ge) begin
					cmd.pop_tail = 1'b1;
					state_d = S_SLAST;
				end else begin
					cmd.fix_last = 1'b1;
					cmd.emit_done = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SLAST: begin
				cmd.rd_tail = 1'b1;
				state_d = S_SCHK;
			end
			S_SFIX: state_d = S_IDLE;
			S_PHEAD: begin
				cmd.rd_head = 1'b1;
				state_d = S_PCHK;
			end
			S_PCHK: begin
				if (!stat.empty && stat.head_le) begin
					cmd.pop_head = 1'b1;
					state_d = S_PHEAD;
				end else begin
					cmd.emit_done = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RINIT: begin
				cmd.rng_init = 1'b1;
				state_d = stat.rng_ok ? S_RRD : S_IDLE;
			end
			S_RRD: begin
				cmd.rd_off = 1'b1;
				state_d = S_REMIT;
			end
			S_REMIT: begin
				cmd.rng_emit = 1'b1;
				state_d = stat.rng_more ? S_RRD : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

/* rtl/sequenced_log_window.sv */
// Top level of the sequenced log window: controller plus datapath.
// Start transfer to result: single-result commands latch, read the head slot, then execute; a
// term lookup that hits a ring slot adds an offset read; truncations read and check per dropped entry.
// Range read: empty answer at setup; each entry takes a slot read, then the result register.
// busy holds from the start transfer until the final result is registered; receiver can't stall.
// arst_n empties the window and zeroes all pointers; ring contents are undefined until written.
module sequenced_log_window
	import slw_pkg::*;
#(
	parameter int LOG_DEPTH    = 64,
	parameter int SEQ_BITS     = 32,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  command,
	input  logic [31:0] seq_arg,
	input  logic [31:0] term_arg,
	input  logic [31:0] payload_in,
	input  logic [6:0]  max_count,
	output logic        strobe,
	output logic [1:0]  status,
	output logic [31:0] seq_out,
	output logic [31:0] term_out,
	output logic [31:0] payload_out,
	output logic        last
);
	slw_cmd_t  cmd;
	slw_stat_t stat;

	// sequencer: one command per transfer, walks entries one at a time, a slot read then an emit each
	slw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
	);

	// ring memory, window pointers and output register
	slw_datapath #(
		.LOG_DEPTH(LOG_DEPTH), .SEQ_BITS(SEQ_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .command(command), .seq_arg(seq_arg),
		.term_arg(term_arg), .payload_in(payload_in), .max_count(max_count),
		.cmd(cmd), .stat(stat), .strobe(strobe), .status(status), .seq_out(seq_out),
		.term_out(term_out), .payload_out(payload_out), .last(last)
	);
endmodule
